// ===== design/sha_pkg.sv =====
// Package for the SHA-256 byte stream hash: round constants, initial hash, shared types.
// Used by all modules in the design folder; depends on nothing.
package sha_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // One classified item from the front end.
   typedef struct packed {
      logic       finish;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LENGTH,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

endpackage

// ===== design/sha_front.sv =====
// Front end of the SHA-256 byte stream hash: accepts items and queues them.
// A two-entry queue decouples input from the compression engine. Uses sha_pkg.
module sha_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_opcode,
   input  logic [7:0]        req_data_byte,
   output logic              item_valid,
   input  logic              item_take,
   output sha_pkg::item_type item
);

   sha_pkg::item_type slot_ff [2];
   sha_pkg::item_type slot_in [2];
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_ready  = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = slot_ff[rd_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_valid && item_take;

   always_comb begin
      slot_in = slot_ff;
      if (push) begin
         slot_in[wr_ff].finish = (req_opcode == sha_pkg::OP_FINISH);
         slot_in[wr_ff].data   = req_data_byte;
      end
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== design/sha_back.sv =====
// Back end of the SHA-256 byte stream hash: block packing, padding, the
// one-round-per-cycle compression, and digest output. Uses sha_pkg.
module sha_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output logic              item_take,
   input  sha_pkg::item_type item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_digest_word,
   output logic [2:0]        rsp_word_index,
   output logic              rsp_last
);

   sha_pkg::state_type state_ff, state_in;
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] wv_ff [8];
   logic [31:0] wv_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [63:0] count_ff, count_in;
   logic [63:0] len_ff, len_in;
   logic        fin_ff, fin_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   // Set once the block that carries the message length has been loaded.
   logic        lendone_ff, lendone_in;

   // Byte insertion and block completion, shared by absorb and padding.
   logic        put;
   logic [7:0]  put_byte;
   logic [3:0]  slot;
   logic [63:0] count_next;
   logic        full;

   logic [31:0] s0, s1, sg0, sg1, ch, mj, t1, t2, wnew;

   // A finish byte of 0x80 may complete the block, land exactly at the length
   // field, or leave zeros to pad first.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE:
            if (item_valid) begin
               if (full) state_in = sha_pkg::ST_ROUND;
               else if (item.finish) begin
                  if (count_next[8:0] == 9'd448) state_in = sha_pkg::ST_LENGTH;
                  else state_in = sha_pkg::ST_PAD;
               end
            end
         sha_pkg::ST_PAD:
            if (full) state_in = sha_pkg::ST_ROUND;
            else if (count_next[8:0] == 9'd448) state_in = sha_pkg::ST_LENGTH;
         sha_pkg::ST_LENGTH: state_in = sha_pkg::ST_ROUND;
         sha_pkg::ST_ROUND:
            if (rnd_ff == 6'd63) state_in = sha_pkg::ST_FOLD;
         sha_pkg::ST_FOLD:
            if (!fin_ff) state_in = sha_pkg::ST_IDLE;
            else if (lendone_ff) state_in = sha_pkg::ST_EMIT;
            else state_in = sha_pkg::ST_PAD;
         sha_pkg::ST_EMIT:
            if (rsp_ready && idx_ff == 3'd7) state_in = sha_pkg::ST_IDLE;
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_take = 1'b0;
      put       = 1'b0;
      put_byte  = 8'h00;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            item_take = item_valid;
            put       = item_valid;
            put_byte  = item.finish ? 8'h80 : item.data;
         end
         sha_pkg::ST_PAD: put = 1'b1;
         default: ;
      endcase
   end

   assign slot       = count_ff[8:5];
   assign count_next = count_ff + 64'd8;
   assign full       = put && (count_next[8:0] == 9'd0);

   assign s1  = {wv_ff[4][5:0], wv_ff[4][31:6]} ^ {wv_ff[4][10:0], wv_ff[4][31:11]}
              ^ {wv_ff[4][24:0], wv_ff[4][31:25]};
   assign s0  = {wv_ff[0][1:0], wv_ff[0][31:2]} ^ {wv_ff[0][12:0], wv_ff[0][31:13]}
              ^ {wv_ff[0][21:0], wv_ff[0][31:22]};
   assign ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
   assign mj  = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
   assign t1  = wv_ff[7] + s1 + ch + sha_pkg::ROUND_K[rnd_ff] + w_ff[0];
   assign t2  = s0 + mj;
   assign sg0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
              ^ {3'b000, w_ff[1][31:3]};
   assign sg1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
              ^ {10'd0, w_ff[14][31:10]};
   assign wnew = sg1 + w_ff[9] + sg0 + w_ff[0];

   always_comb begin
      cv_in      = cv_ff;
      wv_in      = wv_ff;
      w_in       = w_ff;
      count_in   = count_ff;
      len_in     = len_ff;
      fin_in     = fin_ff;
      lendone_in = lendone_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      if (put) begin
         w_in[slot] = {w_ff[slot][23:0], put_byte};
         count_in   = count_next;
      end
      if (state_ff == sha_pkg::ST_IDLE && item_valid && item.finish) begin
         len_in     = count_ff;
         fin_in     = 1'b1;
         lendone_in = 1'b0;
      end
      if (full || state_ff == sha_pkg::ST_LENGTH) begin
         wv_in  = cv_ff;
         rnd_in = 6'd0;
      end
      if (state_ff == sha_pkg::ST_LENGTH) begin
         w_in[14]   = len_ff[63:32];
         w_in[15]   = len_ff[31:0];
         lendone_in = 1'b1;
      end
      if (state_ff == sha_pkg::ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = wnew;
         wv_in[7] = wv_ff[6];
         wv_in[6] = wv_ff[5];
         wv_in[5] = wv_ff[4];
         wv_in[4] = wv_ff[3] + t1;
         wv_in[3] = wv_ff[2];
         wv_in[2] = wv_ff[1];
         wv_in[1] = wv_ff[0];
         wv_in[0] = t1 + t2;
         rnd_in   = rnd_ff + 6'd1;
      end
      if (state_ff == sha_pkg::ST_FOLD) begin
         for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] + wv_ff[i];
         for (int i = 0; i < 16; i++) w_in[i] = 32'd0;
         idx_in = 3'd0;
      end
      if (state_ff == sha_pkg::ST_EMIT && rsp_ready) begin
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'd7) begin
            cv_in    = sha_pkg::INIT_HASH;
            count_in = 64'd0;
            fin_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wv_ff  <= wv_in;
      len_ff <= len_in;
      rnd_ff <= rnd_in;
      idx_ff <= idx_in;
      if (reset) begin
         state_ff   <= sha_pkg::ST_IDLE;
         cv_ff      <= sha_pkg::INIT_HASH;
         w_ff       <= '{default: 32'd0};
         count_ff   <= 64'd0;
         fin_ff     <= 1'b0;
         lendone_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cv_ff      <= cv_in;
         w_ff       <= w_in;
         count_ff   <= count_in;
         fin_ff     <= fin_in;
         lendone_ff <= lendone_in;
      end
   end

   assign rsp_valid       = (state_ff == sha_pkg::ST_EMIT);
   assign rsp_digest_word = cv_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last        = (idx_ff == 3'd7);

endmodule

// ===== design/sha256_byte_stream_hash.sv =====
// SHA-256 over a byte stream. The engine absorbs a byte in its idle state; every
// 64th byte starts a compression of 64 rounds, one per cycle, plus a fold. Finish
// takes padding bytes at one per cycle, one or two compressions, then 8 digest
// transfers, one per cycle unless rsp_ready stalls. Bytes wait while the round unit runs.
// Reset (synchronous, active high) loads the initial hash, clears block and count.
module sha256_byte_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last
);

   // The front queue holds items while the engine is busy compressing.
   logic              item_valid;
   logic              item_take;
   sha_pkg::item_type item;

   sha_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_data_byte,
      .item_valid, .item_take, .item
   );

   // The back end packs bytes, pads, compresses and emits each transfer.
   sha_back u_back (
      .clock, .reset, .item_valid, .item_take, .item,
      .rsp_valid, .rsp_ready, .rsp_digest_word, .rsp_word_index, .rsp_last
   );

`ifndef SYNTHESIS
   // The last flag goes only with the final word of the digest.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == 3'd7)))
      else $error("last flag out of step with word index");
   // A stalled transfer keeps its word index.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("stalled digest word moved");
   // After the last word is taken, no stray word follows at once.
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("digest continued past last word");
`endif

endmodule
